// ----- src/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// psa_pkg
// Shared widths, unit operation codes and handshake types for the principal
// axes block.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int COORD_W   = 24;
    localparam int SUM1_W    = 35;
    localparam int SUM2_W    = 58;
    localparam int WIDE_W    = 72;
    localparam int MUL_B_W   = 35;
    localparam int VEC_W     = 16;
    localparam int NORM_W    = 29;
    localparam int DIV_W     = 48;
    localparam int ROOT_W    = 32;
    localparam int SQRT_TOP  = 62;
    localparam int Q14_SHIFT = 14;
    localparam int TOL_W     = 8;
    localparam int LIM_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [VEC_W-1:0] ONE_Q14 = 16'd16384;

    localparam logic [CFG_IDX_W-1:0] REG_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIM = 1'd1;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_SQRT = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic       neg;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

    function automatic logic [WIDE_W-1:0] mag_w(input logic [WIDE_W-1:0] v);
        return v[WIDE_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ----- src/psa_unit.sv -----
// ----------------------------------------------------------------------------
// psa_unit
// Shared iterative arithmetic unit: shift-add multiply, bit-pair square root
// and restoring division, one step per cycle.
// ----------------------------------------------------------------------------
module psa_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  psa_pkg::unit_req_t          req,
    input  logic [psa_pkg::WIDE_W-1:0]  opa,
    input  logic [psa_pkg::MUL_B_W-1:0] opb,
    output psa_pkg::unit_rsp_t          rsp,
    output logic [psa_pkg::WIDE_W-1:0]  result
);
    import psa_pkg::*;

    localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);
    localparam logic [WIDE_W-1:0] SQRT_BIT0 = WIDE_W'(1) << SQRT_TOP;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [1:0]        op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [WIDE_W-1:0] r0_reg, r0_next;
    logic [WIDE_W-1:0] r1_reg, r1_next;
    logic [WIDE_W-1:0] r2_reg, r2_next;

    logic [WIDE_W-1:0] add_a, add_b, add_sum, sq_diff, sq_root;
    logic [WIDE_W-1:0] rem_sh, div_diff;
    logic              sq_ge, div_ge;

    always_comb
    begin
        logic fin;
        fin       = 1'b0;
        add_a     = (op_reg == OP_MUL) ? r0_reg : r1_reg;
        add_b     = (op_reg == OP_MUL) ? r1_reg : r2_reg;
        add_sum   = add_a + add_b;
        sq_ge     = r0_reg >= add_sum;
        sq_diff   = r0_reg - add_sum;
        sq_root   = (r1_reg >> 1) + r2_reg;
        rem_sh    = {r0_reg[WIDE_W-2:0], r1_reg[DIV_W-1]};
        div_ge    = rem_sh >= r2_reg;
        div_diff  = rem_sh - r2_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        if (req.start)
        begin
            op_next   = req.op;
            neg_next  = req.neg;
            busy_next = 1'b1;
            cnt_next  = '0;
            unique case (req.op)
                OP_MUL:
                begin
                    r0_next = '0;
                    r1_next = opa;
                    r2_next = WIDE_W'(opb);
                end
                OP_SQRT:
                begin
                    r0_next = opa;
                    r1_next = '0;
                    r2_next = SQRT_BIT0;
                end
                OP_DIV:
                begin
                    r0_next = '0;
                    r1_next = opa;
                    r2_next = WIDE_W'(opb);
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    r0_next = r2_reg[0] ? add_sum : r0_reg;
                    r1_next = r1_reg << 1;
                    r2_next = r2_reg >> 1;
                    fin     = (r2_reg[WIDE_W-1:1] == '0);
                end
                OP_SQRT:
                begin
                    if (sq_ge)
                    begin
                        r0_next = sq_diff;
                        r1_next = sq_root;
                    end
                    else
                    begin
                        r1_next = r1_reg >> 1;
                    end
                    r2_next = r2_reg >> 2;
                    fin     = (r2_reg[WIDE_W-1:2] == '0);
                end
                OP_DIV:
                begin
                    r0_next  = div_ge ? div_diff : rem_sh;
                    r1_next  = {r1_reg[WIDE_W-2:0], div_ge};
                    cnt_next = cnt_reg + 6'd1;
                    fin      = (cnt_reg == DIV_LAST);
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
            if (fin)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_MUL:  result = neg_reg ? (~r0_reg + 1'b1) : r0_reg;
            OP_SQRT: result = r1_reg;
            OP_DIV:  result = WIDE_W'(r1_reg[DIV_W-1:0]);
            default: result = r0_reg;
        endcase
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
        r2_reg <= r2_next;
    end

endmodule

// ----- src/point_set_principal_axes_core.sv -----
// Sequencing: a start point is only stored; a counted vertex runs three
// shift-add products in the shared unit (one multiplier bit a cycle).
// The final vertex adds the solve: wide products and, unless the cross term is
// within the limit, a shift loop, two 32-step square roots and two 48-step divisions.
// Throughput: one item at a time; in_ready is low while the sequencer runs.
// Reset: asynchronous, active low; clears sums, counters, state, config registers and output valid.
// ----------------------------------------------------------------------------
// point_set_principal_axes_core
// Accumulates polygon point sums and solves the 2x2 covariance eigenproblem
// with one shared iterative arithmetic unit under a step sequencer.
// ----------------------------------------------------------------------------
module point_set_principal_axes_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [psa_pkg::COORD_W-1:0]   x,
    input  logic signed [psa_pkg::COORD_W-1:0]   y,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [psa_pkg::VEC_W-1:0]     major_x,
    output logic signed [psa_pkg::VEC_W-1:0]     major_y,
    output logic signed [psa_pkg::VEC_W-1:0]     minor_x,
    output logic signed [psa_pkg::VEC_W-1:0]     minor_y,
    input  logic                                 cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psa_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import psa_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_POINTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam logic [4:0] SP_XX   = 5'd0;
    localparam logic [4:0] SP_XY   = 5'd1;
    localparam logic [4:0] SP_YY   = 5'd2;
    localparam logic [4:0] SC_DX   = 5'd3;
    localparam logic [4:0] SC_DY   = 5'd4;
    localparam logic [4:0] SC_OPEN = 5'd5;
    localparam logic [4:0] SM_A1   = 5'd6;
    localparam logic [4:0] SM_A2   = 5'd7;
    localparam logic [4:0] SM_B1   = 5'd8;
    localparam logic [4:0] SM_B2   = 5'd9;
    localparam logic [4:0] SM_D1   = 5'd10;
    localparam logic [4:0] SM_D2   = 5'd11;
    localparam logic [4:0] SC_LIM1 = 5'd12;
    localparam logic [4:0] SC_LIM2 = 5'd13;
    localparam logic [4:0] SC_CMP  = 5'd14;
    localparam logic [4:0] SC_NORM = 5'd15;
    localparam logic [4:0] SC_EE   = 5'd16;
    localparam logic [4:0] SC_FF   = 5'd17;
    localparam logic [4:0] SC_S    = 5'd18;
    localparam logic [4:0] SC_PQ   = 5'd19;
    localparam logic [4:0] SC_PP   = 5'd20;
    localparam logic [4:0] SC_QQ   = 5'd21;
    localparam logic [4:0] SC_LEN  = 5'd22;
    localparam logic [4:0] SC_DIVP = 5'd23;
    localparam logic [4:0] SC_DIVQ = 5'd24;
    localparam logic [4:0] SC_FIN  = 5'd25;

    logic [1:0]               state_reg, state_next;
    logic [4:0]               step_reg, step_next;
    logic                     issued_reg, issued_next;
    logic                     have_start_reg, have_start_next;
    logic                     last_flag_reg, last_flag_next;
    logic                     solving_reg, solving_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [TOL_W-1:0]         tol_reg, tol_next;
    logic [LIM_W-1:0]         lim_reg, lim_next;
    logic signed [SUM1_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SUM2_W-1:0] sxx_reg, sxx_next, sxy_reg, sxy_next, syy_reg, syy_next;
    logic                     out_valid_reg, out_valid_next;

    logic signed [COORD_W-1:0] start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic signed [COORD_W-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [WIDE_W-1:0]  a_reg, a_next, b_reg, b_next, d_reg, d_next;
    logic [WIDE_W-1:0]         tmp_reg, tmp_next;
    logic [WIDE_W:0]           ee_reg, ee_next, ff_reg, ff_next;
    logic                      eneg_reg, eneg_next, bneg_reg, bneg_next;
    logic [ROOT_W-1:0]         s_reg, s_next, p_reg, p_next, q_reg, q_next;
    logic [ROOT_W-1:0]         len_reg, len_next;
    logic signed [VEC_W-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic signed [VEC_W-1:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic signed [VEC_W-1:0]   omx_reg, omx_next, omy_reg, omy_next;
    logic signed [VEC_W-1:0]   onx_reg, onx_next, ony_reg, ony_next;

    unit_req_t         unit_req;
    unit_rsp_t         unit_rsp;
    logic [WIDE_W-1:0] unit_opa;
    logic [MUL_B_W-1:0] unit_opb;
    logic [WIDE_W-1:0] unit_res;
    logic              unit_step;

    logic signed [COORD_W:0] dx, dy;
    logic [WIDE_W-1:0] mag_px, mag_py, mag_dx, mag_dy, mag_sx, mag_sy;
    logic [WIDE_W-1:0] mag_sxx, mag_sxy, mag_syy, mag_b;
    logic [WIDE_W:0]   e_full, mag_e;
    logic [2*TOL_W-1:0] tol_sq;
    logic [DIV_W-1:0]  div_num_p, div_num_q;
    logic              in_accept;

    assign dx      = (COORD_W+1)'(last_x_reg) - (COORD_W+1)'(start_x_reg);
    assign dy      = (COORD_W+1)'(last_y_reg) - (COORD_W+1)'(start_y_reg);
    assign mag_px  = mag_w(WIDE_W'(px_reg));
    assign mag_py  = mag_w(WIDE_W'(py_reg));
    assign mag_dx  = mag_w(WIDE_W'(dx));
    assign mag_dy  = mag_w(WIDE_W'(dy));
    assign mag_sx  = mag_w(WIDE_W'(sx_reg));
    assign mag_sy  = mag_w(WIDE_W'(sy_reg));
    assign mag_sxx = mag_w(WIDE_W'(sxx_reg));
    assign mag_sxy = mag_w(WIDE_W'(sxy_reg));
    assign mag_syy = mag_w(WIDE_W'(syy_reg));
    assign mag_b   = mag_w(b_reg);
    assign e_full  = {a_reg[WIDE_W-1], a_reg} - {d_reg[WIDE_W-1], d_reg};
    assign mag_e   = e_full[WIDE_W] ? (~e_full + 1'b1) : e_full;
    assign tol_sq  = (2*TOL_W)'(tol_reg) * (2*TOL_W)'(tol_reg);
    assign div_num_p = (DIV_W'(p_reg) << Q14_SHIFT) + DIV_W'(len_reg >> 1);
    assign div_num_q = (DIV_W'(q_reg) << Q14_SHIFT) + DIV_W'(len_reg >> 1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign major_x   = omx_reg;
    assign major_y   = omy_reg;
    assign minor_x   = onx_reg;
    assign minor_y   = ony_reg;

    always_comb
    begin
        unit_step    = 1'b1;
        unit_req.op  = OP_MUL;
        unit_req.neg = 1'b0;
        unit_opa     = '0;
        unit_opb     = '0;
        unique case (step_reg)
            SP_XX:
            begin
                unit_opa = mag_px;
                unit_opb = mag_px[MUL_B_W-1:0];
            end
            SP_XY:
            begin
                unit_opa     = mag_px;
                unit_opb     = mag_py[MUL_B_W-1:0];
                unit_req.neg = px_reg[COORD_W-1] ^ py_reg[COORD_W-1];
            end
            SP_YY:
            begin
                unit_opa = mag_py;
                unit_opb = mag_py[MUL_B_W-1:0];
            end
            SC_DX:
            begin
                unit_opa = mag_dx;
                unit_opb = mag_dx[MUL_B_W-1:0];
            end
            SC_DY:
            begin
                unit_opa = mag_dy;
                unit_opb = mag_dy[MUL_B_W-1:0];
            end
            SM_A1:
            begin
                unit_opa     = mag_sxx;
                unit_opb     = MUL_B_W'(n_reg);
                unit_req.neg = sxx_reg[SUM2_W-1];
            end
            SM_A2:
            begin
                unit_opa = mag_sx;
                unit_opb = mag_sx[MUL_B_W-1:0];
            end
            SM_B1:
            begin
                unit_opa     = mag_sxy;
                unit_opb     = MUL_B_W'(n_reg);
                unit_req.neg = sxy_reg[SUM2_W-1];
            end
            SM_B2:
            begin
                unit_opa     = mag_sx;
                unit_opb     = mag_sy[MUL_B_W-1:0];
                unit_req.neg = sx_reg[SUM1_W-1] ^ sy_reg[SUM1_W-1];
            end
            SM_D1:
            begin
                unit_opa     = mag_syy;
                unit_opb     = MUL_B_W'(n_reg);
                unit_req.neg = syy_reg[SUM2_W-1];
            end
            SM_D2:
            begin
                unit_opa = mag_sy;
                unit_opb = mag_sy[MUL_B_W-1:0];
            end
            SC_LIM1:
            begin
                unit_opa = WIDE_W'(lim_reg);
                unit_opb = MUL_B_W'(n_reg);
            end
            SC_LIM2:
            begin
                unit_opa = tmp_reg;
                unit_opb = MUL_B_W'(n_reg);
            end
            SC_EE:
            begin
                unit_opa = WIDE_W'(ee_reg[NORM_W-1:0]);
                unit_opb = MUL_B_W'(ee_reg[NORM_W-1:0]);
            end
            SC_FF:
            begin
                unit_opa = WIDE_W'(ff_reg[NORM_W-1:0]);
                unit_opb = MUL_B_W'(ff_reg[NORM_W-1:0]);
            end
            SC_S, SC_LEN:
            begin
                unit_req.op = OP_SQRT;
                unit_opa    = tmp_reg;
            end
            SC_PP:
            begin
                unit_opa = WIDE_W'(p_reg);
                unit_opb = MUL_B_W'(p_reg);
            end
            SC_QQ:
            begin
                unit_opa = WIDE_W'(q_reg);
                unit_opb = MUL_B_W'(q_reg);
            end
            SC_DIVP:
            begin
                unit_req.op = OP_DIV;
                unit_opa    = WIDE_W'(div_num_p);
                unit_opb    = MUL_B_W'(len_reg);
            end
            SC_DIVQ:
            begin
                unit_req.op = OP_DIV;
                unit_opa    = WIDE_W'(div_num_q);
                unit_opb    = MUL_B_W'(len_reg);
            end
            default:
            begin
                unit_step = 1'b0;
            end
        endcase
        unit_req.start = (state_reg == ST_EXEC) && unit_step && !issued_reg &&
                         !unit_rsp.busy && !unit_rsp.done;
    end

    psa_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (unit_req),
        .opa    (unit_opa),
        .opb    (unit_opb),
        .rsp    (unit_rsp),
        .result (unit_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        issued_next     = issued_reg;
        have_start_next = have_start_reg;
        last_flag_next  = last_flag_reg;
        solving_next    = solving_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        tol_next        = tol_reg;
        lim_next        = lim_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        sxx_next        = sxx_reg;
        sxy_next        = sxy_reg;
        syy_next        = syy_reg;
        out_valid_next  = out_valid_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        d_next          = d_reg;
        tmp_next        = tmp_reg;
        ee_next         = ee_reg;
        ff_next         = ff_reg;
        eneg_next       = eneg_reg;
        bneg_next       = bneg_reg;
        s_next          = s_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        len_next        = len_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        omx_next        = omx_reg;
        omy_next        = omy_reg;
        onx_next        = onx_reg;
        ony_next        = ony_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOL: tol_next = cfg_data[TOL_W-1:0];
                REG_LIM: lim_next = cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!have_start_reg)
                    begin
                        start_x_next    = x;
                        start_y_next    = y;
                        have_start_next = 1'b1;
                    end
                    else
                    begin
                        last_x_next    = x;
                        last_y_next    = y;
                        last_flag_next = last;
                        if (cnt_reg < CNT_LIMIT)
                        begin
                            px_next    = x;
                            py_next    = y;
                            sx_next    = sx_reg + SUM1_W'(x);
                            sy_next    = sy_reg + SUM1_W'(y);
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = ST_EXEC;
                            step_next  = SP_XX;
                        end
                        else if (last)
                        begin
                            state_next = ST_EXEC;
                            step_next  = SC_DX;
                        end
                    end
                end
            end
            ST_EXEC:
            begin
                if (!unit_step)
                begin
                    case (step_reg)
                        SC_OPEN:
                        begin
                            if (tmp_reg > WIDE_W'(tol_sq))
                            begin
                                px_next      = start_x_reg;
                                py_next      = start_y_reg;
                                sx_next      = sx_reg + SUM1_W'(start_x_reg);
                                sy_next      = sy_reg + SUM1_W'(start_y_reg);
                                n_next       = cnt_reg + 1'b1;
                                solving_next = 1'b1;
                                step_next    = SP_XX;
                            end
                            else
                            begin
                                n_next    = cnt_reg;
                                step_next = SM_A1;
                            end
                        end
                        SC_CMP:
                        begin
                            bneg_next = b_reg[WIDE_W-1];
                            if (mag_b <= tmp_reg)
                            begin
                                if (!e_full[WIDE_W])
                                begin
                                    mx_next = ONE_Q14;
                                    my_next = '0;
                                    nx_next = '0;
                                    ny_next = ONE_Q14;
                                end
                                else
                                begin
                                    mx_next = '0;
                                    my_next = ONE_Q14;
                                    nx_next = ONE_Q14;
                                    ny_next = '0;
                                end
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                ee_next   = mag_e;
                                ff_next   = {mag_b, 1'b0};
                                eneg_next = e_full[WIDE_W];
                                step_next = SC_NORM;
                            end
                        end
                        SC_NORM:
                        begin
                            if ((ee_reg[WIDE_W:NORM_W] != '0) || (ff_reg[WIDE_W:NORM_W] != '0))
                            begin
                                ee_next = ee_reg >> 1;
                                ff_next = ff_reg >> 1;
                            end
                            else
                            begin
                                step_next = SC_EE;
                            end
                        end
                        SC_PQ:
                        begin
                            if (!eneg_reg)
                            begin
                                p_next = ROOT_W'(ee_reg[NORM_W-1:0]) + s_reg;
                                q_next = ROOT_W'(ff_reg[NORM_W-1:0]);
                            end
                            else
                            begin
                                p_next = ROOT_W'(ff_reg[NORM_W-1:0]);
                                q_next = s_reg + ROOT_W'(ee_reg[NORM_W-1:0]);
                            end
                            step_next = SC_PP;
                        end
                        SC_FIN:
                        begin
                            if (bneg_reg)
                            begin
                                nx_next = my_reg;
                                ny_next = -mx_reg;
                                mx_next = -mx_reg;
                            end
                            else
                            begin
                                nx_next = -my_reg;
                                ny_next = mx_reg;
                            end
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else if (unit_rsp.done)
                begin
                    issued_next = 1'b0;
                    case (step_reg)
                        SP_XX:
                        begin
                            sxx_next  = sxx_reg + $signed(unit_res[SUM2_W-1:0]);
                            step_next = SP_XY;
                        end
                        SP_XY:
                        begin
                            sxy_next  = sxy_reg + $signed(unit_res[SUM2_W-1:0]);
                            step_next = SP_YY;
                        end
                        SP_YY:
                        begin
                            syy_next = syy_reg + $signed(unit_res[SUM2_W-1:0]);
                            if (!last_flag_reg)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (solving_reg)
                            begin
                                step_next = SM_A1;
                            end
                            else
                            begin
                                step_next = SC_DX;
                            end
                        end
                        SC_DX:
                        begin
                            tmp_next  = unit_res;
                            step_next = SC_DY;
                        end
                        SC_DY:
                        begin
                            tmp_next  = tmp_reg + unit_res;
                            step_next = SC_OPEN;
                        end
                        SM_A1:
                        begin
                            a_next    = $signed(unit_res);
                            step_next = SM_A2;
                        end
                        SM_A2:
                        begin
                            a_next    = a_reg - $signed(unit_res);
                            step_next = SM_B1;
                        end
                        SM_B1:
                        begin
                            b_next    = $signed(unit_res);
                            step_next = SM_B2;
                        end
                        SM_B2:
                        begin
                            b_next    = b_reg - $signed(unit_res);
                            step_next = SM_D1;
                        end
                        SM_D1:
                        begin
                            d_next    = $signed(unit_res);
                            step_next = SM_D2;
                        end
                        SM_D2:
                        begin
                            d_next    = d_reg - $signed(unit_res);
                            step_next = SC_LIM1;
                        end
                        SC_LIM1:
                        begin
                            tmp_next  = unit_res;
                            step_next = SC_LIM2;
                        end
                        SC_LIM2:
                        begin
                            tmp_next  = unit_res;
                            step_next = SC_CMP;
                        end
                        SC_EE:
                        begin
                            tmp_next  = unit_res;
                            step_next = SC_FF;
                        end
                        SC_FF:
                        begin
                            tmp_next  = tmp_reg + unit_res;
                            step_next = SC_S;
                        end
                        SC_S:
                        begin
                            s_next    = unit_res[ROOT_W-1:0];
                            step_next = SC_PQ;
                        end
                        SC_PP:
                        begin
                            tmp_next  = unit_res;
                            step_next = SC_QQ;
                        end
                        SC_QQ:
                        begin
                            tmp_next  = tmp_reg + unit_res;
                            step_next = SC_LEN;
                        end
                        SC_LEN:
                        begin
                            len_next  = (unit_res == '0) ? ROOT_W'(1) : unit_res[ROOT_W-1:0];
                            step_next = SC_DIVP;
                        end
                        SC_DIVP:
                        begin
                            mx_next   = unit_res[VEC_W-1:0];
                            step_next = SC_DIVQ;
                        end
                        SC_DIVQ:
                        begin
                            my_next   = unit_res[VEC_W-1:0];
                            step_next = SC_FIN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else if (unit_req.start)
                begin
                    issued_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    omx_next        = mx_reg;
                    omy_next        = my_reg;
                    onx_next        = nx_reg;
                    ony_next        = ny_reg;
                    out_valid_next  = 1'b1;
                    have_start_next = 1'b0;
                    solving_next    = 1'b0;
                    last_flag_next  = 1'b0;
                    cnt_next        = '0;
                    sx_next         = '0;
                    sy_next         = '0;
                    sxx_next        = '0;
                    sxy_next        = '0;
                    syy_next        = '0;
                    start_x_next    = '0;
                    start_y_next    = '0;
                    last_x_next     = '0;
                    last_y_next     = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= SP_XX;
            issued_reg     <= 1'b0;
            have_start_reg <= 1'b0;
            last_flag_reg  <= 1'b0;
            solving_reg    <= 1'b0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            tol_reg        <= '0;
            lim_reg        <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            sxx_reg        <= '0;
            sxy_reg        <= '0;
            syy_reg        <= '0;
            out_valid_reg  <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            issued_reg     <= issued_next;
            have_start_reg <= have_start_next;
            last_flag_reg  <= last_flag_next;
            solving_reg    <= solving_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            tol_reg        <= tol_next;
            lim_reg        <= lim_next;
            sx_reg         <= sx_next;
            sy_reg         <= sy_next;
            sxx_reg        <= sxx_next;
            sxy_reg        <= sxy_next;
            syy_reg        <= syy_next;
            out_valid_reg  <= out_valid_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        tmp_reg  <= tmp_next;
        ee_reg   <= ee_next;
        ff_reg   <= ff_next;
        eneg_reg <= eneg_next;
        bneg_reg <= bneg_next;
        s_reg    <= s_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        len_reg  <= len_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        omx_reg  <= omx_next;
        omy_reg  <= omy_next;
        onx_reg  <= onx_next;
        ony_reg  <= ony_next;
    end

endmodule

// ----- src/psa_checker.sv -----
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks on result delivery for the principal axes block.
// ----------------------------------------------------------------------------
module psa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [psa_pkg::VEC_W-1:0] major_x,
    input logic signed [psa_pkg::VEC_W-1:0] major_y,
    input logic signed [psa_pkg::VEC_W-1:0] minor_x,
    input logic signed [psa_pkg::VEC_W-1:0] minor_y
);
    import psa_pkg::*;

    localparam logic signed [VEC_W-1:0] POS_ONE = ONE_Q14;
    localparam logic signed [VEC_W-1:0] NEG_ONE = -ONE_Q14;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(major_x) && $stable(major_y)
            && $stable(minor_x) && $stable(minor_y))
        else $error("result item changed while stalled");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && in_ready |=> !out_valid)
        else $error("result item repeated after delivery");

    a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result item appeared without a solve");

    a_axes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (major_y >= 0) && (major_y <= POS_ONE)
            && (major_x <= POS_ONE) && (major_x >= NEG_ONE)
            && ((minor_x == major_y) || (minor_x == -major_y))
            && ((minor_y == major_x) || (minor_y == -major_x)))
        else $error("result axes out of range or not perpendicular");

endmodule

bind point_set_principal_axes_core psa_checker u_psa_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for point_set_principal_axes_core. Polygons are streamed
// through the valid/ready input with random gaps, and the output is stalled at
// random. Every accepted item runs through a local model of the sums and the
// eigen solve. Each result is checked against the oldest queued axis pair.
// A short directed table comes first, then random polygons under several
// register settings, including one polygon that overflows the vertex limit.
// ----------------------------------------------------------------------------
module testbench;
    import psa_pkg::*;

    localparam int MAX_VERTS = 1024;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [VEC_W-1:0] mj_x;
        logic [VEC_W-1:0] mj_y;
        logic [VEC_W-1:0] mn_x;
        logic [VEC_W-1:0] mn_y;
    } axes_t;

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      lst;
        logic                      typed;
        axes_t                     ax;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic last;
    logic out_valid;
    logic out_ready;
    logic signed [VEC_W-1:0] major_x;
    logic signed [VEC_W-1:0] major_y;
    logic signed [VEC_W-1:0] minor_x;
    logic signed [VEC_W-1:0] minor_y;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    point_set_principal_axes_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .x(x), .y(y), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .major_x(major_x), .major_y(major_y), .minor_x(minor_x), .minor_y(minor_y),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    axes_t axes_due[$];
    row_t  dir_rows[$];
    int    errors = 0;
    int    items_sent = 0;
    bit    busy_mode = 1;

    longint tol_m, lim_m;
    longint start_x, start_y, tail_x, tail_y, nverts;
    longint sx, sy, sxx, sxy, syy;
    bit     have_start_m;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void add_row(input row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void clear_polygon();
        start_x = 0; start_y = 0; tail_x = 0; tail_y = 0;
        have_start_m = 0;
        nverts = 0;
        sx = 0; sy = 0; sxx = 0; sxy = 0; syy = 0;
    endfunction

    function automatic void accumulate(input longint px, input longint py);
        sx += px; sy += py;
        sxx += px * px; sxy += px * py; syy += py * py;
    endfunction

    function automatic axes_t solve_axes();
        longint dx, dy, n, mx, my, nx, ny;
        wide_t a, b, d, e, mb;
        logic [127:0] me, mf;
        longint unsigned ev, fv, s, p, q, len;
        axes_t r;
        dx = tail_x - start_x;
        dy = tail_y - start_y;
        n = nverts;
        if (longint'(dx * dx + dy * dy) > tol_m * tol_m)
        begin
            accumulate(start_x, start_y);
            n++;
        end
        a = wide_t'(n) * wide_t'(sxx) - wide_t'(sx) * wide_t'(sx);
        b = wide_t'(n) * wide_t'(sxy) - wide_t'(sx) * wide_t'(sy);
        d = wide_t'(n) * wide_t'(syy) - wide_t'(sy) * wide_t'(sy);
        e = a - d;
        mb = (b < 0) ? -b : b;
        if (mb <= wide_t'(lim_m * n * n))
        begin
            if (e >= 0)
            begin
                mx = ONE_Q14; my = 0; nx = 0; ny = ONE_Q14;
            end
            else
            begin
                mx = 0; my = ONE_Q14; nx = ONE_Q14; ny = 0;
            end
        end
        else
        begin
            me = (e < 0) ? -e : e;
            mf = mb << 1;
            while (me >= (128'd1 << 29) || mf >= (128'd1 << 29))
            begin
                me = me >> 1;
                mf = mf >> 1;
            end
            ev = me[63:0];
            fv = mf[63:0];
            s = int_sqrt(ev * ev + fv * fv);
            if (e >= 0)
            begin
                p = ev + s; q = fv;
            end
            else
            begin
                p = fv; q = s + ev;
            end
            len = int_sqrt(p * p + q * q);
            if (len == 0) len = 1;
            mx = longint'((p * ONE_Q14 + len / 2) / len);
            my = longint'((q * ONE_Q14 + len / 2) / len);
            if (b < 0)
            begin
                nx = my; ny = -mx; mx = -mx;
            end
            else
            begin
                nx = -my; ny = mx;
            end
        end
        r.mj_x = mx[15:0];
        r.mj_y = my[15:0];
        r.mn_x = nx[15:0];
        r.mn_y = ny[15:0];
        return r;
    endfunction

    // Returns 1 when the item closes a polygon, with its axes in ax.
    function automatic bit step_polygon(input longint px, input longint py, input bit lst,
                                        output axes_t ax);
        ax = '0;
        if (!have_start_m)
        begin
            start_x = px; start_y = py;
            have_start_m = 1;
            return 0;
        end
        tail_x = px; tail_y = py;
        if (nverts < MAX_VERTS - 1)
        begin
            accumulate(px, py);
            nverts++;
        end
        if (!lst) return 0;
        ax = solve_axes();
        clear_polygon();
        return 1;
    endfunction

    function automatic int gap_len();
        int r;
        if (!busy_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input bit lst, input bit typed, input axes_t typed_ax);
        axes_t ax;
        int g;
        @(negedge clk);
        x <= px;
        y <= py;
        last <= lst;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (step_polygon(px, py, lst, ax))
            axes_due.insert(axes_due.size(), typed ? typed_ax : ax);
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DAT_W-1:0];
        if (idx == REG_TOL) tol_m = val & 8'hFF;
        else lim_m = val & 16'hFFFF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (axes_due.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(input int kind);
        case (kind)
            0: return COORD_W'($urandom());
            1: return COORD_W'($urandom_range(0, 1000) - 500);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            default: return COORD_W'($urandom_range(0, 8) - 4);
        endcase
    endfunction

    task automatic random_polygon(input int nv);
        int kind, k;
        logic signed [COORD_W-1:0] px, py, s0x, s0y;
        kind = $urandom_range(0, 4);
        s0x = pick_coord(kind == 4 ? 1 : kind);
        s0y = pick_coord(kind == 4 ? 3 : kind);
        send_point(s0x, s0y, ($urandom_range(0, 7) == 0), 0, '0);
        for (k = 1; k <= nv; k++)
        begin
            case (kind)
                3: begin px = pick_coord(1); py = pick_coord(3); end
                4: begin px = pick_coord(3); py = pick_coord(1); end
                default: begin px = pick_coord(kind); py = pick_coord(kind); end
            endcase
            if (k == nv && $urandom_range(0, 1))
            begin
                px = COORD_W'(s0x + $signed($urandom_range(0, 400)) - 200);
                py = COORD_W'(s0y + $signed($urandom_range(0, 400)) - 200);
            end
            send_point(px, py, (k == nv), 0, '0);
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        x = 0; y = 0; last = 0;
        cfg_we = 0; cfg_index = REG_TOL; cfg_data = 0;
        tol_m = 0; lim_m = 0;
        clear_polygon();

        add_row('{24'sd0, 24'sd0, 1'b1, 1'b0, '0});
        add_row('{24'sd0, 24'sd0, 1'b1, 1'b1, '{16'd16384, 16'd0, 16'd0, 16'd16384}});
        add_row('{24'sd0, 24'sd0, 1'b0, 1'b0, '0});
        add_row('{24'sd0, 24'sd256, 1'b0, 1'b0, '0});
        add_row('{24'sd0, 24'sd512, 1'b1, 1'b1, '{16'd0, 16'd16384, 16'd16384, 16'd0}});
        add_row('{24'sh7FFFFF, -24'sh800000, 1'b0, 1'b0, '0});
        add_row('{-24'sh800000, 24'sh7FFFFF, 1'b0, 1'b0, '0});
        add_row('{24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0, '0});
        add_row('{-24'sh800000, -24'sh800000, 1'b0, 1'b0, '0});
        add_row('{-24'sh800000, 24'sh7FFFFF, 1'b1, 1'b1,
                  '{16'd0, 16'd16384, 16'd16384, 16'd0}});
        add_row('{-24'sh800000, 24'sd0, 1'b0, 1'b0, '0});
        add_row('{24'sh7FFFFF, 24'sd0, 1'b1, 1'b1,
                  '{16'd16384, 16'd0, 16'd0, 16'd16384}});
        add_row('{24'sd0, 24'sd0, 1'b0, 1'b0, '0});
        add_row('{24'sd256, 24'sd256, 1'b0, 1'b0, '0});
        add_row('{24'sd512, 24'sd512, 1'b1, 1'b0, '0});
        add_row('{24'sd0, 24'sd0, 1'b0, 1'b0, '0});
        add_row('{24'sd256, -24'sd256, 1'b0, 1'b0, '0});
        add_row('{24'sd512, -24'sd512, 1'b1, 1'b0, '0});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (dir_rows[i])
            send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].lst,
                       dir_rows[i].typed, dir_rows[i].ax);
        drain();

        for (int ph = 0; items_sent < 1700; ph++)
        begin
            case (ph % 6)
                0: begin write_reg(REG_TOL, 255); write_reg(REG_LIM, 65535); end
                1: begin write_reg(REG_TOL, 0); write_reg(REG_LIM, 0); end
                2: begin write_reg(REG_TOL, 255); write_reg(REG_LIM, 0); end
                3: begin write_reg(REG_TOL, 0); write_reg(REG_LIM, 65535); end
                default:
                begin
                    write_reg(REG_TOL, $urandom_range(0, 255));
                    write_reg(REG_LIM, $urandom_range(0, 65535));
                end
            endcase
            busy_mode = (ph % 4 != 3);
            if (ph == 2)
                random_polygon(MAX_VERTS + 6);
            for (int k = 0; k < 25 && items_sent < 1700; k++)
                random_polygon($urandom_range(0, 9) == 0 ? $urandom_range(13, 40)
                                                         : $urandom_range(1, 12));
            drain();
        end

        wait (axes_due.size() == 0);
        repeat (800) @(posedge clk);
        if (errors == 0)
            $display("** point_set_principal_axes_core: PASSED **");
        else
            $display("** point_set_principal_axes_core: FAILED **");
        $finish;
    end

    initial
    begin
        int hold;
        out_ready = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (busy_mode && $urandom_range(0, 99) < 30)
            begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                   : $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        axes_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (axes_due.size() == 0)
            begin
                $display("%0t: unexpected result %h %h %h %h", $time,
                         major_x, major_y, minor_x, minor_y);
                errors++;
            end
            else
            begin
                want = axes_due.pop_front();
                if (major_x !== want.mj_x)
                begin
                    $display("%0t: major_x expected %h got %h", $time, want.mj_x, major_x);
                    errors++;
                end
                if (major_y !== want.mj_y)
                begin
                    $display("%0t: major_y expected %h got %h", $time, want.mj_y, major_y);
                    errors++;
                end
                if (minor_x !== want.mn_x)
                begin
                    $display("%0t: minor_x expected %h got %h", $time, want.mn_x, minor_x);
                    errors++;
                end
                if (minor_y !== want.mn_y)
                begin
                    $display("%0t: minor_y expected %h got %h", $time, want.mn_y, minor_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("** point_set_principal_axes_core: FAILED **");
        $finish;
    end

endmodule
